// ----- sv/c2p_pkg.sv -----
// Shared types, widths, angle constants and arctangent table for the polar converter.
`default_nettype none

package c2p_pkg;

	// Field widths
	localparam int LEG_W     = 24;
	localparam int LIMIT_W   = 23;
	localparam int ANGLE_W   = 25;
	localparam int LEN_W     = 24;
	localparam int QUAD_W    = 3;

	// Internal widths
	localparam int SUM_W      = 2 * LEG_W;
	localparam int GUARD      = 8;
	localparam int CW         = LEG_W + GUARD + 3;
	localparam int ZW         = 29;
	localparam int ALPHA_W    = 23;
	localparam int ROOT_STEPS = LEN_W;
	localparam int REM_W      = LEN_W + 3;

	// Iteration count bounds
	localparam int ITER_DEFAULT = 20;
	localparam int ITER_MAX     = 32;

	// Register map (index taken from paddr[2])
	localparam int  ADDR_W       = 3;
	localparam logic REG_NEAR_ZERO = 1'b0;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);

	// Quadrant codes
	typedef logic [QUAD_W-1:0] quad_t;
	localparam quad_t QUAD_1 = 3'd1;
	localparam quad_t QUAD_2 = 3'd2;
	localparam quad_t QUAD_3 = 3'd3;
	localparam quad_t QUAD_4 = 3'd4;

	// Angles in Q9.16 degrees
	localparam logic [ANGLE_W-1:0] DEG_90  = ANGLE_W'(90 * 65536);
	localparam logic [ANGLE_W-1:0] DEG_180 = ANGLE_W'(180 * 65536);
	localparam logic [ANGLE_W-1:0] DEG_270 = ANGLE_W'(270 * 65536);
	localparam logic [ANGLE_W-1:0] DEG_360 = ANGLE_W'(360 * 65536);

	// Accumulator ceiling: 90 degrees with 20 fraction bits
	localparam logic signed [ZW-1:0] Z_MAX = ZW'(90 * 1048576);

	// Facts about the vector that travel alongside the datapath
	typedef struct packed {
		logic  x_small;
		logic  y_small;
		logic  x_pos;
		logic  y_pos;
		quad_t quad;
	} side_t;

	// Rotation state of the vectoring pass
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} rot_t;

	// Digit-by-digit square root state
	typedef struct packed {
		logic [SUM_W-1:0] rad;
		logic [REM_W-1:0] rem;
		logic [LEN_W-1:0] root;
	} root_t;

	// atan(2^-i) in degrees, 20 fraction bits, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_entry(input int idx);
		logic signed [ZW-1:0] v;
		case (idx)
			0:  v = ZW'(47185920);
			1:  v = ZW'(27855475);
			2:  v = ZW'(14718068);
			3:  v = ZW'(7471121);
			4:  v = ZW'(3750058);
			5:  v = ZW'(1876857);
			6:  v = ZW'(938658);
			7:  v = ZW'(469357);
			8:  v = ZW'(234682);
			9:  v = ZW'(117342);
			10: v = ZW'(58671);
			11: v = ZW'(29335);
			12: v = ZW'(14668);
			13: v = ZW'(7334);
			14: v = ZW'(3667);
			15: v = ZW'(1833);
			16: v = ZW'(917);
			17: v = ZW'(458);
			18: v = ZW'(229);
			19: v = ZW'(115);
			20: v = ZW'(57);
			21: v = ZW'(29);
			22: v = ZW'(14);
			23: v = ZW'(7);
			24: v = ZW'(4);
			25: v = ZW'(2);
			26: v = ZW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- sv/cartesian_to_polar_degrees.sv -----
// Top level of the cartesian to polar converter: stream ports, register port, stage chain.
//
// Converts a signed Q8.16 vector (x, y) into its angle in degrees (Q9.16, 0 to below 360),
// its rounded length sqrt(x*x+y*y) (Q8.16) and its quadrant. One vector is taken per clock
// while no finished result waits at the output; the depth is set by the unrolled chain of
// CORDIC rotation and square root digit stages (two input stages, one stage per CORDIC step
// or root digit, two output stages). The whole chain holds when a finished result is not
// taken. Legs whose magnitude is strictly below the near_zero_limit register (address 0,
// reset 1) count as zero and give fixed angles.
`default_nettype none

module cartesian_to_polar_degrees #(
	parameter int ANGLE_ITERATIONS = c2p_pkg::ITER_DEFAULT
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// input stream
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [47:0]                s_tdata,  // x_leg[23:0], y_leg[47:24]
	// output stream
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [55:0]                     m_tdata,  // angle_degrees[24:0], length[48:25],
	                                                  // quadrant[51:49], zero[55:52]
	// register port
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [c2p_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	localparam int LW    = c2p_pkg::LEG_W;
	localparam int DEPTH = (ANGLE_ITERATIONS > c2p_pkg::ROOT_STEPS) ?
		ANGLE_ITERATIONS : c2p_pkg::ROOT_STEPS;

	logic [c2p_pkg::LIMIT_W-1:0] limit_q;
	logic                        en;

	logic                        valid_c [DEPTH+1];
	c2p_pkg::side_t              side_c  [DEPTH+1];
	c2p_pkg::rot_t               rot_c   [DEPTH+1];
	c2p_pkg::root_t              root_c  [DEPTH+1];

	logic [c2p_pkg::ANGLE_W-1:0] angle;
	logic [c2p_pkg::LEN_W-1:0]   len;
	c2p_pkg::quad_t              quad;

	// Register port: write on the access phase, read back the limit
	assign pready = 1'b1;
	assign prdata = (paddr[2] == c2p_pkg::REG_NEAR_ZERO) ? 32'(limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= c2p_pkg::LIMIT_RESET;
		end else if (psel && penable && pwrite && pready
				&& (paddr[2] == c2p_pkg::REG_NEAR_ZERO)) begin
			limit_q <= pwdata[c2p_pkg::LIMIT_W-1:0];
		end
	end

	// Hold the whole chain while the output transfer waits
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	c2p_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.x_leg    (s_tdata[LW-1:0]),
		.y_leg    (s_tdata[2*LW-1:LW]),
		.limit    (limit_q),
		.valid_s2 (valid_c[0]),
		.side_s2  (side_c[0]),
		.rot_s2   (rot_c[0]),
		.root_s2  (root_c[0])
	);

	for (genvar k = 0; k < DEPTH; k++) begin : g_stage
		c2p_stage #(
			.STAGE (k),
			.ITERS (ANGLE_ITERATIONS)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (valid_c[k]),
			.in_side   (side_c[k]),
			.in_rot    (rot_c[k]),
			.in_root   (root_c[k]),
			.out_valid (valid_c[k+1]),
			.out_side  (side_c[k+1]),
			.out_rot   (rot_c[k+1]),
			.out_root  (root_c[k+1])
		);
	end

	c2p_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_c[DEPTH]),
		.in_side   (side_c[DEPTH]),
		.in_rot    (rot_c[DEPTH]),
		.in_root   (root_c[DEPTH]),
		.valid_s2  (m_tvalid),
		.angle_s2  (angle),
		.length_s2 (len),
		.quad_s2   (quad)
	);

	assign m_tdata = {4'b0000, quad, len, angle};

endmodule

`default_nettype wire

// ----- sv/c2p_prep.sv -----
// Input stages: leg magnitudes, near-zero flags, quadrant, squares and their sum.
`default_nettype none

module c2p_prep (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic                              in_valid,
	input  wire logic signed [c2p_pkg::LEG_W-1:0]  x_leg,
	input  wire logic signed [c2p_pkg::LEG_W-1:0]  y_leg,
	input  wire logic [c2p_pkg::LIMIT_W-1:0]       limit,
	output logic                                   valid_s2,
	output c2p_pkg::side_t                         side_s2,
	output c2p_pkg::rot_t                          rot_s2,
	output c2p_pkg::root_t                         root_s2
);

	localparam int LW = c2p_pkg::LEG_W;
	localparam int SW = c2p_pkg::SUM_W;
	localparam int CW = c2p_pkg::CW;

	logic [LW-1:0]        ax, ay;
	logic signed [SW-1:0] xx, yy;
	c2p_pkg::side_t       side;
	c2p_pkg::quad_t       quad;

	logic                 valid_s1;
	logic [LW-1:0]        ax_s1, ay_s1;
	logic [SW-1:0]        xx_s1, yy_s1;
	c2p_pkg::side_t       side_s1;

	// Magnitudes, squares and classification
	always_comb begin
		ax = x_leg[LW-1] ? LW'(-x_leg) : LW'(x_leg);
		ay = y_leg[LW-1] ? LW'(-y_leg) : LW'(y_leg);
		xx = x_leg * x_leg;
		yy = y_leg * y_leg;
		if (!x_leg[LW-1]) begin
			quad = y_leg[LW-1] ? c2p_pkg::QUAD_4 : c2p_pkg::QUAD_1;
		end else begin
			quad = y_leg[LW-1] ? c2p_pkg::QUAD_3 : c2p_pkg::QUAD_2;
		end
		side.x_small = ax < LW'(limit);
		side.y_small = ay < LW'(limit);
		side.x_pos   = !x_leg[LW-1] && (x_leg != '0);
		side.y_pos   = !y_leg[LW-1] && (y_leg != '0);
		side.quad    = quad;
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 1: magnitudes and squares
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1   <= ax;
			ay_s1   <= ay;
			xx_s1   <= SW'(xx);
			yy_s1   <= SW'(yy);
			side_s1 <= side;
		end
	end

	// Stage 2: sum of squares and seed of the rotation
	always_ff @(posedge clk) begin
		if (en) begin
			side_s2      <= side_s1;
			rot_s2.x     <= CW'({ax_s1, {c2p_pkg::GUARD{1'b0}}});
			rot_s2.y     <= CW'({ay_s1, {c2p_pkg::GUARD{1'b0}}});
			rot_s2.z     <= '0;
			root_s2.rad  <= xx_s1 + yy_s1;
			root_s2.rem  <= '0;
			root_s2.root <= '0;
		end
	end

endmodule

`default_nettype wire

// ----- sv/c2p_stage.sv -----
// One pipeline stage: a CORDIC vectoring step, a root digit, or both.
`default_nettype none

module c2p_stage #(
	parameter int STAGE = 0,
	parameter int ITERS = c2p_pkg::ITER_DEFAULT
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire c2p_pkg::side_t  in_side,
	input  wire c2p_pkg::rot_t   in_rot,
	input  wire c2p_pkg::root_t  in_root,
	output logic                 out_valid,
	output c2p_pkg::side_t       out_side,
	output c2p_pkg::rot_t        out_rot,
	output c2p_pkg::root_t       out_root
);

	localparam int CW = c2p_pkg::CW;
	localparam int RW = c2p_pkg::REM_W;
	localparam int NW = c2p_pkg::LEN_W;
	localparam int SW = c2p_pkg::SUM_W;

	logic signed [CW-1:0] x, y, dx, dy;
	logic                 rotate_down;
	c2p_pkg::rot_t        rot_n;
	logic [RW-1:0]        rem_sh, trial;
	c2p_pkg::root_t       root_n;

	// Rotate towards the x axis
	always_comb begin
		x           = in_rot.x;
		y           = in_rot.y;
		dx          = y >>> STAGE;
		dy          = x >>> STAGE;
		rotate_down = !y[CW-1] && (y != '0);
		rot_n       = in_rot;
		if (STAGE < ITERS) begin
			if (rotate_down) begin
				rot_n.x = x + dx;
				rot_n.y = y - dy;
				rot_n.z = in_rot.z + c2p_pkg::atan_entry(STAGE);
			end else begin
				rot_n.x = x - dx;
				rot_n.y = y + dy;
				rot_n.z = in_rot.z - c2p_pkg::atan_entry(STAGE);
			end
		end
	end

	// Bring down two radicand bits and try the next root digit
	always_comb begin
		rem_sh = {in_root.rem[RW-3:0], in_root.rad[SW-1 -: 2]};
		trial  = RW'({in_root.root, 2'b01});
		root_n = in_root;
		if (STAGE < c2p_pkg::ROOT_STEPS) begin
			root_n.rad = {in_root.rad[SW-3:0], 2'b00};
			if (rem_sh >= trial) begin
				root_n.rem  = rem_sh - trial;
				root_n.root = {in_root.root[NW-2:0], 1'b1};
			end else begin
				root_n.rem  = rem_sh;
				root_n.root = {in_root.root[NW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_side <= in_side;
			out_rot  <= rot_n;
			out_root <= root_n;
		end
	end

endmodule

`default_nettype wire

// ----- sv/c2p_finish.sv -----
// Output stages: angle clamp and rounding, root rounding, quadrant placement.
`default_nettype none

module c2p_finish (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            en,
	input  wire logic                            in_valid,
	input  wire c2p_pkg::side_t                  in_side,
	input  wire c2p_pkg::rot_t                   in_rot,
	input  wire c2p_pkg::root_t                  in_root,
	output logic                                 valid_s2,
	output logic [c2p_pkg::ANGLE_W-1:0]          angle_s2,
	output logic [c2p_pkg::LEN_W-1:0]            length_s2,
	output c2p_pkg::quad_t                       quad_s2
);

	localparam int AW = c2p_pkg::ANGLE_W;
	localparam int PW = c2p_pkg::ALPHA_W;
	localparam int NW = c2p_pkg::LEN_W;
	localparam int RW = c2p_pkg::REM_W;
	localparam int ZW = c2p_pkg::ZW;

	logic signed [ZW-1:0] zc, zr;
	logic [PW-1:0]        alpha;
	logic [NW-1:0]        len;

	logic                 valid_s1;
	logic [PW-1:0]        alpha_s1;
	logic [NW-1:0]        len_s1;
	c2p_pkg::side_t       side_s1;

	logic [AW-1:0]        a, placed, angle;

	// Clamp to [0,90] and round half up to 16 fraction bits; round root to nearest
	always_comb begin
		if (in_rot.z[ZW-1]) begin
			zc = '0;
		end else if (in_rot.z > c2p_pkg::Z_MAX) begin
			zc = c2p_pkg::Z_MAX;
		end else begin
			zc = in_rot.z;
		end
		zr    = zc + ZW'(8);
		alpha = PW'(zr >>> 4);
		len   = in_root.root + NW'(in_root.rem > RW'(in_root.root));
	end

	// Place the first-quadrant angle and apply the near-zero cases
	always_comb begin
		a = AW'(alpha_s1);
		case (side_s1.quad)
			c2p_pkg::QUAD_1: placed = a;
			c2p_pkg::QUAD_2: placed = c2p_pkg::DEG_180 - a;
			c2p_pkg::QUAD_3: placed = c2p_pkg::DEG_180 + a;
			c2p_pkg::QUAD_4: placed = (a == '0) ? '0 : c2p_pkg::DEG_360 - a;
			default:         placed = a;
		endcase
		if (side_s1.x_small) begin
			if (side_s1.y_small) begin
				angle = '0;
			end else begin
				angle = side_s1.y_pos ? c2p_pkg::DEG_90 : c2p_pkg::DEG_270;
			end
		end else if (side_s1.y_small) begin
			angle = side_s1.x_pos ? '0 : c2p_pkg::DEG_180;
		end else begin
			angle = placed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s1  <= alpha;
			len_s1    <= len;
			side_s1   <= in_side;
			angle_s2  <= angle;
			length_s2 <= len_s1;
			quad_s2   <= side_s1.quad;
		end
	end

endmodule

`default_nettype wire
